// ----- hw/rtl/tbta_pkg.sv -----
// package for the time bucket tick aggregator
// widths, sequencer state type and divider control structs; no dependencies
`default_nettype none

package tbta_pkg;

   localparam int TIME_BITS   = 48;
   localparam int PRICE_BITS  = 32;
   localparam int IN_VOL_BITS = 32;
   localparam int VOL_BITS    = 48;
   localparam int PERIOD_BITS = 32;
   localparam int CNT_BITS    = $clog2(TIME_BITS);

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1000);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_OPEN
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [TIME_BITS-1:0]   dividend;
      logic [PERIOD_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [PERIOD_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tbta_req_if.sv -----
// tick input channel: valid/ready with the tick payload
// depends on tbta_pkg for field widths
`default_nettype none

interface tbta_req_if;
   logic                            valid;
   logic                            ready;
   logic [tbta_pkg::TIME_BITS-1:0]   tick_time_ms;
   logic [tbta_pkg::PRICE_BITS-1:0]  tick_price;
   logic [tbta_pkg::IN_VOL_BITS-1:0] tick_volume;

   modport source (output valid, tick_time_ms, tick_price, tick_volume, input ready);
   modport sink   (input valid, tick_time_ms, tick_price, tick_volume, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbta_rsp_if.sv -----
// closed bar output channel: valid/ready with the bar payload
// depends on tbta_pkg for field widths
`default_nettype none

interface tbta_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tbta_pkg::TIME_BITS-1:0]  bar_start_ms;
   logic [tbta_pkg::PRICE_BITS-1:0] bar_high;
   logic [tbta_pkg::PRICE_BITS-1:0] bar_low;
   logic [tbta_pkg::VOL_BITS-1:0]   bar_volume;

   modport source (output valid, bar_start_ms, bar_high, bar_low, bar_volume, input ready);
   modport sink   (input valid, bar_start_ms, bar_high, bar_low, bar_volume, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbta_csr_if.sv -----
// configuration write channel: valid/ready with the bucket period
// depends on tbta_pkg for the register width
`default_nettype none

interface tbta_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tbta_pkg::PERIOD_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbta_div.sv -----
// serial restoring divider, one quotient bit per cycle, remainder only
// depends on tbta_pkg for widths and the div_req_type / div_rsp_type structs
`default_nettype none

module tbta_div (
   input  wire                   clock,
   input  wire                   reset,
   input  tbta_pkg::div_req_type req,
   output tbta_pkg::div_rsp_type rsp
);

   logic [tbta_pkg::TIME_BITS-1:0]   dvd_ff, dvd_in;
   logic [tbta_pkg::PERIOD_BITS-1:0] dvs_ff, dvs_in;
   logic [tbta_pkg::PERIOD_BITS-1:0] rem_ff, rem_in;
   logic [tbta_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   logic [tbta_pkg::PERIOD_BITS:0]   shifted;
   logic [tbta_pkg::PERIOD_BITS:0]   diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[tbta_pkg::TIME_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = tbta_pkg::CNT_BITS'(tbta_pkg::TIME_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[tbta_pkg::TIME_BITS-2:0], 1'b0};
         // shifted stays below twice the divisor, so one subtract restores
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[tbta_pkg::PERIOD_BITS-1:0];
         end else begin
            rem_in = shifted[tbta_pkg::PERIOD_BITS-1:0];
         end
         cnt_in = cnt_ff - tbta_pkg::CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/time_bucket_tick_aggregator_top.sv -----
// time bucket tick aggregator: groups trade ticks into fixed-length time bars
// depends on tbta_pkg, tbta_req_if, tbta_rsp_if, tbta_csr_if and tbta_div
//
// usage:
//   req carries ticks (time in ms, price, volume), rsp carries closed bars
//   (aligned start, high, low, saturating volume sum), csr writes the bucket
//   period in ms (zero acts as one). csr is always ready; write it only while
//   the block is idle.
//   a tick that folds into the open bar passes through accept and evaluate.
//   a tick that opens a bar (first tick, or one that closes the previous bar)
//   goes through accept, evaluate, divide and open; its aligned start comes
//   from a serial divider, one quotient bit per cycle over the 48 time bits.
//   a closed bar appears on rsp once the accepted tick is evaluated, and stays
//   in the output register until taken; req.ready is high only in the idle
//   state, so a new tick can be accepted while a bar waits on rsp. a tick that
//   would close another bar while the output register is still full waits
//   in the evaluate state until the receiver takes the pending bar.
//   reset sets the period to 1000, drops the open bar and empties rsp; the
//   last open bar is never flushed.
`default_nettype none

module time_bucket_tick_aggregator_top (
   input  wire         clock,
   input  wire         reset,
   tbta_req_if.sink    req,
   tbta_rsp_if.source  rsp,
   tbta_csr_if.sink    csr
);

   tbta_pkg::state_type state_ff, state_in;

   logic [tbta_pkg::PERIOD_BITS-1:0] period_ff, period_in;
   logic [tbta_pkg::PERIOD_BITS-1:0] cur_period_ff, cur_period_in;

   logic [tbta_pkg::TIME_BITS-1:0]   tick_time_ff, tick_time_in;
   logic [tbta_pkg::PRICE_BITS-1:0]  tick_price_ff, tick_price_in;
   logic [tbta_pkg::IN_VOL_BITS-1:0] tick_vol_ff, tick_vol_in;

   logic                             open_ff, open_in;
   logic [tbta_pkg::TIME_BITS-1:0]   open_start_ff, open_start_in;
   logic [tbta_pkg::PRICE_BITS-1:0]  open_high_ff, open_high_in;
   logic [tbta_pkg::PRICE_BITS-1:0]  open_low_ff, open_low_in;
   logic [tbta_pkg::VOL_BITS-1:0]    open_vol_ff, open_vol_in;

   logic                             out_valid_ff, out_valid_in;
   logic [tbta_pkg::TIME_BITS-1:0]   out_start_ff, out_start_in;
   logic [tbta_pkg::PRICE_BITS-1:0]  out_high_ff, out_high_in;
   logic [tbta_pkg::PRICE_BITS-1:0]  out_low_ff, out_low_in;
   logic [tbta_pkg::VOL_BITS-1:0]    out_vol_ff, out_vol_in;

   tbta_pkg::div_req_type div_req;
   tbta_pkg::div_rsp_type div_rsp;

   logic                             accept;
   logic                             out_free;
   logic [tbta_pkg::TIME_BITS-1:0]   elapsed;
   logic                             closes;
   logic [tbta_pkg::VOL_BITS:0]      vol_sum;

   // control decoded from the state
   logic                             do_close;
   logic                             do_fold;
   logic                             do_open;

   tbta_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept   = req.valid && req.ready;
   assign out_free = !out_valid_ff || rsp.ready;
   assign elapsed  = tick_time_ff - open_start_ff;
   assign closes   = open_ff && (tick_time_ff >= open_start_ff)
                     && (elapsed >= tbta_pkg::TIME_BITS'(cur_period_ff));
   assign vol_sum  = {1'b0, open_vol_ff} + (tbta_pkg::VOL_BITS + 1)'(tick_vol_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbta_pkg::ST_IDLE: begin
            if (accept) state_in = tbta_pkg::ST_EVAL;
         end
         tbta_pkg::ST_EVAL: begin
            if (!open_ff) begin
               state_in = tbta_pkg::ST_DIVIDE;
            end else if (closes) begin
               if (out_free) state_in = tbta_pkg::ST_DIVIDE;
            end else begin
               state_in = tbta_pkg::ST_IDLE;
            end
         end
         tbta_pkg::ST_DIVIDE: begin
            if (div_rsp.done) state_in = tbta_pkg::ST_OPEN;
         end
         tbta_pkg::ST_OPEN: begin
            state_in = tbta_pkg::ST_IDLE;
         end
         default: state_in = tbta_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req.ready        = 1'b0;
      do_close         = 1'b0;
      do_fold          = 1'b0;
      do_open          = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = tick_time_ff;
      div_req.divisor  = cur_period_ff;
      case (state_ff)
         tbta_pkg::ST_IDLE: begin
            req.ready = 1'b1;
         end
         tbta_pkg::ST_EVAL: begin
            if (!open_ff) begin
               div_req.start = 1'b1;
            end else if (closes) begin
               if (out_free) begin
                  do_close      = 1'b1;
                  div_req.start = 1'b1;
               end
            end else begin
               do_fold = 1'b1;
            end
         end
         tbta_pkg::ST_DIVIDE: begin
         end
         tbta_pkg::ST_OPEN: begin
            do_open = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      period_in     = period_ff;
      cur_period_in = cur_period_ff;
      tick_time_in  = tick_time_ff;
      tick_price_in = tick_price_ff;
      tick_vol_in   = tick_vol_ff;
      open_in       = open_ff;
      open_start_in = open_start_ff;
      open_high_in  = open_high_ff;
      open_low_in   = open_low_ff;
      open_vol_in   = open_vol_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_start_in  = out_start_ff;
      out_high_in   = out_high_ff;
      out_low_in    = out_low_ff;
      out_vol_in    = out_vol_ff;

      if (csr.valid) period_in = csr.data;

      if (accept) begin
         tick_time_in  = req.tick_time_ms;
         tick_price_in = req.tick_price;
         tick_vol_in   = req.tick_volume;
         // zero period behaves as one
         cur_period_in = (period_ff == '0) ? tbta_pkg::PERIOD_BITS'(1) : period_ff;
      end

      if (do_close) begin
         out_valid_in = 1'b1;
         out_start_in = open_start_ff;
         out_high_in  = open_high_ff;
         out_low_in   = open_low_ff;
         out_vol_in   = open_vol_ff;
         open_in      = 1'b0;
      end

      if (do_fold) begin
         if (tick_price_ff > open_high_ff) open_high_in = tick_price_ff;
         if (tick_price_ff < open_low_ff)  open_low_in  = tick_price_ff;
         // saturate on carry out of the volume sum
         if (vol_sum[tbta_pkg::VOL_BITS]) begin
            open_vol_in = '1;
         end else begin
            open_vol_in = vol_sum[tbta_pkg::VOL_BITS-1:0];
         end
      end

      if (do_open) begin
         open_in       = 1'b1;
         open_start_in = tick_time_ff - tbta_pkg::TIME_BITS'(div_rsp.remainder);
         open_high_in  = tick_price_ff;
         open_low_in   = tick_price_ff;
         open_vol_in   = tbta_pkg::VOL_BITS'(tick_vol_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbta_pkg::ST_IDLE;
         period_ff    <= tbta_pkg::PERIOD_RESET;
         open_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         open_ff      <= open_in;
         out_valid_ff <= out_valid_in;
      end
      cur_period_ff <= cur_period_in;
      tick_time_ff  <= tick_time_in;
      tick_price_ff <= tick_price_in;
      tick_vol_ff   <= tick_vol_in;
      open_start_ff <= open_start_in;
      open_high_ff  <= open_high_in;
      open_low_ff   <= open_low_in;
      open_vol_ff   <= open_vol_in;
      out_start_ff  <= out_start_in;
      out_high_ff   <= out_high_in;
      out_low_ff    <= out_low_in;
      out_vol_ff    <= out_vol_in;
   end

   assign csr.ready        = 1'b1;
   assign rsp.valid        = out_valid_ff;
   assign rsp.bar_start_ms = out_start_ff;
   assign rsp.bar_high     = out_high_ff;
   assign rsp.bar_low      = out_low_ff;
   assign rsp.bar_volume   = out_vol_ff;

endmodule

`default_nettype wire
